@@ rtl/core/dcep_pkg.sv @@
`default_nettype none

package dcep_pkg;

  // request kinds on the input channel
  typedef enum logic [1:0] {
    REQ_RECEIVE = 2'd0,
    REQ_LOCAL_OPEN = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_COMMIT = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_PARSE = 3'd1,
    ST_PROTOCOL = 3'd2,
    ST_NOT_IMPL = 3'd3,
    ST_FULL = 3'd4,
    ST_SMALL = 3'd5,
    ST_NO_DATA = 3'd6
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_ACT = 2'd2
  } state_t;

  // work to do for the current request
  typedef enum logic [2:0] {
    OP_DONE = 3'd0,
    OP_RX_OPEN = 3'd1,
    OP_RX_ACK = 3'd2,
    OP_LOCAL = 3'd3,
    OP_PEEK = 3'd4,
    OP_COMMIT = 3'd5
  } op_t;

  localparam logic [31:0] PPID_CONTROL = 32'd50;
  localparam logic [7:0] MSG_OPEN = 8'd3;
  localparam logic [7:0] MSG_ACK = 8'd2;

  // pending message codes as stored per entry
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ACK = 2'd2;
  localparam logic [1:0] PEND_OPEN = 2'd3;

  // channel type bits
  localparam logic [7:0] CTYPE_RELI_MASK = 8'h7f;
  localparam logic [7:0] CTYPE_UNORDERED = 8'h80;
  localparam logic [7:0] CTYPE_MAX_RELI = 8'd1;

  // message sizes in bytes
  localparam logic [15:0] OPEN_HDR_BYTES = 16'd12;
  localparam logic [15:0] ACK_BYTES = 16'd1;

endpackage

`default_nettype wire

@@ rtl/core/dcep_channel_table_engine_unit.sv @@
// Data channel table engine: keeps up to MAX_CHANNELS channel entries in one
// synchronous memory. Entries are appended and never freed.
// Input channel (in_valid / in_stall): one request per beat; receive checks a
// parsed control header, local open appends an opening entry, peek reports
// the first pending message, commit clears the pending message of a stream.
// Result channel (out_valid / out_stall): exactly one result beat per request.
// Request flow: accept, then, unless no lookup is needed, a scan of the table
// at one entry read per cycle (memory read port with registered read data),
// then an update step that writes the table and loads the output register.
// One request is in work at a time; a new request is taken as soon as the
// previous one has loaded the output register.
// When out_stall holds a result, the next request may be accepted and scanned,
// but its table update and result wait until the output register is free.
// Reset (rst_n low, synchronous) empties the table by clearing the entry
// count; memory contents are not cleared and need no clearing pass.
`default_nettype none

module dcep_channel_table_engine_unit #(
  parameter int MAX_CHANNELS = 8,
  parameter int LABEL_BYTES = 32
) (
  input wire logic clk,
  input wire logic rst_n,

  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] in_req_type,
  input wire logic [15:0] in_stream_num,
  input wire logic [31:0] in_ppid,
  input wire logic [15:0] in_msg_len,
  input wire logic [7:0] in_msg_type,
  input wire logic [7:0] in_chan_kind,
  input wire logic [31:0] in_reliability,
  input wire logic [15:0] in_lbl_len,
  input wire logic [15:0] in_proto_len,
  input wire logic in_ordered,
  input wire logic [15:0] in_retx_limit,
  input wire logic [15:0] in_out_capacity,

  output logic out_valid,
  input wire logic out_stall,
  output logic [2:0] out_status,
  output logic out_opened,
  output logic [15:0] out_stream,
  output logic [7:0] out_kind,
  output logic [7:0] out_chan_type,
  output logic [15:0] out_retx,
  output logic [4:0] out_lbl_len,
  output logic [5:0] out_len
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int LW = $clog2(LABEL_BYTES);
  localparam int NW = LW + 5;
  localparam logic [15:0] LAB_MAX16 = 16'(LABEL_BYTES - 1);
  localparam logic [LW-1:0] LAB_MAX = LW'(LABEL_BYTES - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_CHANNELS);

  typedef struct packed {
    logic [15:0] stream;
    logic is_open;
    logic [7:0] ctype;
    logic [15:0] retx;
    logic [LW-1:0] lab;
    logic [1:0] pend;
  } entry_t;

  // channel table memory
  entry_t mem [MAX_CHANNELS];
  entry_t mem_rdata_r;
  entry_t mem_wdata;
  logic mem_re;
  logic mem_we;
  logic [IW-1:0] mem_raddr;
  logic [IW-1:0] mem_waddr;

  // sequencer state
  dcep_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] issue_r, issue_nxt;
  logic rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic found_r, found_nxt;

  // latched request payload
  dcep_pkg::op_t op_r, op_nxt;
  dcep_pkg::status_t early_st_r, early_st_nxt;
  logic [15:0] sid_r;
  logic [7:0] ctype_r, ctype_sel;
  logic [15:0] retx_r, retx_sel;
  logic [LW-1:0] lab_r, lab_clip;
  logic unsup_r, unsup_sel;
  logic [15:0] cap_r;

  // output register
  logic out_valid_r, out_valid_nxt;
  dcep_pkg::status_t st_r, st_nxt;
  logic opened_r, opened_nxt;
  logic [15:0] o_stream_r, o_stream_nxt;
  logic [7:0] o_kind_r, o_kind_nxt;
  logic [7:0] o_ctype_r, o_ctype_nxt;
  logic [15:0] o_retx_r, o_retx_nxt;
  logic [4:0] o_lab_r, o_lab_nxt;
  logic [5:0] o_len_r, o_len_nxt;

  logic in_acc;
  logic out_free;
  logic table_full;
  logic scan_match;
  logic hdr_bad;
  logic [16:0] lab_prot_sum;
  logic [16:0] open_body;
  logic [NW-1:0] need;
  logic [NW-1:0] open_need;
  logic [NW:0] lab_ext;

  assign in_stall = (state_r != dcep_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign table_full = (used_r == FULL_COUNT);

  // open header consistency: label plus protocol must fit the body
  assign lab_prot_sum = {1'b0, in_lbl_len} + {1'b0, in_proto_len};
  assign open_body = {1'b0, in_msg_len - dcep_pkg::OPEN_HDR_BYTES};
  assign hdr_bad = (in_msg_len < dcep_pkg::OPEN_HDR_BYTES) || (lab_prot_sum > open_body);

  // label length clipped to the label buffer
  assign lab_clip = (in_lbl_len >= LAB_MAX16) ? LAB_MAX : in_lbl_len[LW-1:0];

  // request classification at accept
  always_comb begin
    op_nxt = dcep_pkg::OP_DONE;
    early_st_nxt = dcep_pkg::ST_OK;
    ctype_sel = in_chan_kind;
    retx_sel = in_reliability[15:0];
    unsup_sel = ((in_chan_kind & dcep_pkg::CTYPE_RELI_MASK) > dcep_pkg::CTYPE_MAX_RELI) ||
                (|in_reliability[31:16]);
    case (dcep_pkg::req_t'(in_req_type))
      dcep_pkg::REQ_RECEIVE: begin
        if (in_ppid != dcep_pkg::PPID_CONTROL) begin
          op_nxt = dcep_pkg::OP_DONE;
        end else if (in_msg_len == 16'd0) begin
          early_st_nxt = dcep_pkg::ST_PARSE;
        end else if (in_msg_type == dcep_pkg::MSG_OPEN) begin
          if (hdr_bad) begin
            early_st_nxt = dcep_pkg::ST_PARSE;
          end else begin
            op_nxt = dcep_pkg::OP_RX_OPEN;
          end
        end else if (in_msg_type == dcep_pkg::MSG_ACK) begin
          op_nxt = dcep_pkg::OP_RX_ACK;
        end else begin
          early_st_nxt = dcep_pkg::ST_PROTOCOL;
        end
      end
      dcep_pkg::REQ_LOCAL_OPEN: begin
        op_nxt = dcep_pkg::OP_LOCAL;
        ctype_sel = {~in_ordered, 6'd0, |in_retx_limit};
        retx_sel = in_retx_limit;
      end
      dcep_pkg::REQ_PEEK: begin
        op_nxt = dcep_pkg::OP_PEEK;
      end
      dcep_pkg::REQ_COMMIT: begin
        op_nxt = dcep_pkg::OP_COMMIT;
      end
      default: begin
        op_nxt = dcep_pkg::OP_DONE;
      end
    endcase
  end

  // hit test on the entry read last cycle
  assign scan_match = (op_r == dcep_pkg::OP_PEEK) ? (mem_rdata_r.pend != dcep_pkg::PEND_NONE)
                                                  : (mem_rdata_r.stream == sid_r);

  // size of the peeked message
  assign lab_ext = {6'd0, mem_rdata_r.lab};
  assign open_need = NW'(dcep_pkg::OPEN_HDR_BYTES) + NW'(mem_rdata_r.lab);
  assign need = (mem_rdata_r.pend == dcep_pkg::PEND_ACK) ? NW'(dcep_pkg::ACK_BYTES) : open_need;

  // next state, memory access and result
  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    issue_nxt = issue_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    found_nxt = found_r;
    mem_re = 1'b0;
    mem_raddr = issue_r[IW-1:0];
    mem_we = 1'b0;
    mem_waddr = rd_idx_r;
    mem_wdata = mem_rdata_r;
    out_valid_nxt = out_valid_r && out_stall;
    st_nxt = st_r;
    opened_nxt = opened_r;
    o_stream_nxt = o_stream_r;
    o_kind_nxt = o_kind_r;
    o_ctype_nxt = o_ctype_r;
    o_retx_nxt = o_retx_r;
    o_lab_nxt = o_lab_r;
    o_len_nxt = o_len_r;
    case (state_r)
      dcep_pkg::S_IDLE: begin
        issue_nxt = '0;
        found_nxt = 1'b0;
        if (in_acc) begin
          if (op_nxt == dcep_pkg::OP_DONE || op_nxt == dcep_pkg::OP_LOCAL) begin
            state_nxt = dcep_pkg::S_ACT;
          end else begin
            state_nxt = dcep_pkg::S_SCAN;
          end
        end
      end
      dcep_pkg::S_SCAN: begin
        if (rd_vld_r && scan_match) begin
          found_nxt = 1'b1;
          state_nxt = dcep_pkg::S_ACT;
        end else if (issue_r < used_r) begin
          mem_re = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = issue_r[IW-1:0];
          issue_nxt = issue_r + 1'b1;
        end else begin
          state_nxt = dcep_pkg::S_ACT;
        end
      end
      dcep_pkg::S_ACT: begin
        if (out_free) begin
          state_nxt = dcep_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
          st_nxt = dcep_pkg::ST_OK;
          opened_nxt = 1'b0;
          o_stream_nxt = '0;
          o_kind_nxt = '0;
          o_ctype_nxt = '0;
          o_retx_nxt = '0;
          o_lab_nxt = '0;
          o_len_nxt = '0;
          // new entry for an append
          mem_wdata.stream = sid_r;
          mem_wdata.ctype = ctype_r;
          mem_wdata.retx = retx_r;
          mem_wdata.lab = lab_r;
          case (op_r)
            dcep_pkg::OP_DONE: begin
              st_nxt = early_st_r;
            end
            dcep_pkg::OP_RX_OPEN: begin
              if (found_r) begin
                mem_wdata = mem_rdata_r;
                mem_wdata.pend = dcep_pkg::PEND_ACK;
                mem_we = 1'b1;
              end else if (unsup_r) begin
                st_nxt = dcep_pkg::ST_NOT_IMPL;
              end else if (table_full) begin
                st_nxt = dcep_pkg::ST_FULL;
              end else begin
                mem_wdata.is_open = 1'b1;
                mem_wdata.pend = dcep_pkg::PEND_ACK;
                mem_waddr = used_r[IW-1:0];
                mem_we = 1'b1;
                used_nxt = used_r + 1'b1;
                opened_nxt = 1'b1;
              end
            end
            dcep_pkg::OP_RX_ACK: begin
              if (found_r && !mem_rdata_r.is_open) begin
                mem_wdata = mem_rdata_r;
                mem_wdata.is_open = 1'b1;
                mem_we = 1'b1;
                opened_nxt = 1'b1;
              end
            end
            dcep_pkg::OP_LOCAL: begin
              if (table_full) begin
                st_nxt = dcep_pkg::ST_FULL;
              end else begin
                mem_wdata.is_open = 1'b0;
                mem_wdata.pend = dcep_pkg::PEND_OPEN;
                mem_waddr = used_r[IW-1:0];
                mem_we = 1'b1;
                used_nxt = used_r + 1'b1;
              end
            end
            dcep_pkg::OP_PEEK: begin
              if (!found_r) begin
                st_nxt = dcep_pkg::ST_NO_DATA;
              end else if (cap_r < 16'(need)) begin
                st_nxt = dcep_pkg::ST_SMALL;
              end else begin
                o_stream_nxt = mem_rdata_r.stream;
                o_kind_nxt = {6'd0, mem_rdata_r.pend};
                o_len_nxt = need[5:0];
                if (mem_rdata_r.pend != dcep_pkg::PEND_ACK) begin
                  o_ctype_nxt = mem_rdata_r.ctype;
                  o_retx_nxt = mem_rdata_r.retx;
                  o_lab_nxt = lab_ext[4:0];
                end
              end
            end
            dcep_pkg::OP_COMMIT: begin
              if (found_r) begin
                mem_wdata = mem_rdata_r;
                mem_wdata.pend = dcep_pkg::PEND_NONE;
                mem_we = 1'b1;
              end
            end
            default: begin
              st_nxt = early_st_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = dcep_pkg::S_IDLE;
      end
    endcase
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcep_pkg::S_IDLE;
      used_r <= '0;
      issue_r <= '0;
      rd_vld_r <= 1'b0;
      found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      issue_r <= issue_nxt;
      rd_vld_r <= rd_vld_nxt;
      found_r <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request payload, captured on an accepted beat
  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    if (in_acc) begin
      op_r <= op_nxt;
      early_st_r <= early_st_nxt;
      sid_r <= in_stream_num;
      ctype_r <= ctype_sel;
      retx_r <= retx_sel;
      lab_r <= lab_clip;
      unsup_r <= unsup_sel;
      cap_r <= in_out_capacity;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    opened_r <= opened_nxt;
    o_stream_r <= o_stream_nxt;
    o_kind_r <= o_kind_nxt;
    o_ctype_r <= o_ctype_nxt;
    o_retx_r <= o_retx_nxt;
    o_lab_r <= o_lab_nxt;
    o_len_r <= o_len_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = st_r;
  assign out_opened = opened_r;
  assign out_stream = o_stream_r;
  assign out_kind = o_kind_r;
  assign out_chan_type = o_ctype_r;
  assign out_retx = o_retx_r;
  assign out_lbl_len = o_lab_r;
  assign out_len = o_len_r;

endmodule

`default_nettype wire
